/* rtl/tcw_pkg.sv */
package tcw_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_INDEX_W     = 4;

  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = CFG_INDEX_W'(1);

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET    = 7'd25;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_CLEAR,
    BK_COPY,
    BK_BLANK
  } back_state_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic        put_cell;
    logic        do_scroll;
    logic        do_clear;
    logic        do_read;
    logic [6:0]  cell_row;
    logic [7:0]  cell_col;
    logic [31:0] cell_word;
    logic [6:0]  nrows;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic        scrolled;
    logic [31:0] cell_data;
  } res_t;

endpackage

/* rtl/tcw_if.sv */
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] character;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [5:0] read_row;
  logic [6:0] read_column;

  modport source (output valid, operation, character, red, green, blue, read_row,
                  read_column, input ready);
  modport sink   (input valid, operation, character, red, green, blue, read_row,
                  read_column, output ready);
endinterface

interface tcw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_column;
  logic [5:0] cursor_row;
  logic       scrolled;
  logic [7:0] cell_character;
  logic [7:0] cell_red;
  logic [7:0] cell_green;
  logic [7:0] cell_blue;

  modport source (output valid, cursor_column, cursor_row, scrolled, cell_character,
                  cell_red, cell_green, cell_blue, input ready);
  modport sink   (input valid, cursor_column, cursor_row, scrolled, cell_character,
                  cell_red, cell_green, cell_blue, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tcw_front.sv */
module tcw_front import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_cfg_if.sink    cfg_ch,
  input  logic       q_full,
  input  logic       init_busy,
  output logic       q_push,
  output cmd_t       push_cmd
);

  localparam logic [8:0] MAXC = 9'(MAX_COLUMNS);
  localparam logic [7:0] MAXR = 8'(MAX_ROWS);

  logic [7:0] columns_r, columns_nxt;
  logic [6:0] rows_r, rows_nxt;
  logic [6:0] cur_col_r, cur_col_nxt;
  logic [5:0] cur_row_r, cur_row_nxt;

  logic [7:0] ncols;
  logic [6:0] nrows;
  logic [7:0] col;
  logic [6:0] row;
  logic [7:0] wcol;
  logic [6:0] wrow;
  logic       put_cell;
  logic       scroll;
  logic       accept;

  assign in_ch.ready  = ~q_full & ~init_busy;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid & in_ch.ready;
  assign q_push       = accept;

  // effective grid size
  always_comb begin
    ncols = columns_r;
    if (columns_r == 8'd0) begin
      ncols = 8'd1;
    end else if ({1'b0, columns_r} > MAXC) begin
      ncols = MAXC[7:0];
    end
    nrows = rows_r;
    if (rows_r == 7'd0) begin
      nrows = 7'd1;
    end else if ({1'b0, rows_r} > MAXR) begin
      nrows = MAXR[6:0];
    end
  end

  // cursor motion for a put
  always_comb begin
    col = {1'b0, cur_col_r};
    row = {1'b0, cur_row_r};
    if (col >= ncols) col = ncols - 8'd1;
    if (row >= nrows) row = nrows - 7'd1;
    wcol     = col;
    wrow     = row;
    put_cell = 1'b0;
    scroll   = 1'b0;
    if (in_ch.character == CHAR_NEWLINE) begin
      col = 8'd0;
      row = row + 7'd1;
    end else if (in_ch.character == CHAR_BACKSPACE) begin
      if (col != 8'd0) begin
        col = col - 8'd1;
      end else if (row != 7'd0) begin
        col = ncols - 8'd1;
        row = row - 7'd1;
      end
    end else begin
      put_cell = 1'b1;
      col      = col + 8'd1;
    end
    if (col >= ncols) begin
      col = 8'd0;
      row = row + 7'd1;
    end
    if (row >= nrows) begin
      scroll = 1'b1;
      row    = nrows - 7'd1;
    end
  end

  always_comb begin
    push_cmd            = '0;
    push_cmd.nrows      = nrows;
    push_cmd.cursor_col = cur_col_r;
    push_cmd.cursor_row = cur_row_r;
    cur_col_nxt         = cur_col_r;
    cur_row_nxt         = cur_row_r;
    case (op_t'(in_ch.operation))
      OP_PUT: begin
        push_cmd.put_cell   = put_cell;
        push_cmd.do_scroll  = scroll;
        push_cmd.cell_row   = wrow;
        push_cmd.cell_col   = wcol;
        push_cmd.cell_word  = {in_ch.character, in_ch.red, in_ch.green, in_ch.blue};
        push_cmd.cursor_col = col[6:0];
        push_cmd.cursor_row = row[5:0];
        cur_col_nxt         = col[6:0];
        cur_row_nxt         = row[5:0];
      end
      OP_CLEAR: begin
        push_cmd.do_clear   = 1'b1;
        push_cmd.cursor_col = 7'd0;
        push_cmd.cursor_row = 6'd0;
        cur_col_nxt         = 7'd0;
        cur_row_nxt         = 6'd0;
      end
      OP_READ: begin
        // out-of-range reads answer a zero cell without touching the grid
        if (({1'b0, in_ch.read_row} < nrows) && ({1'b0, in_ch.read_column} < ncols)) begin
          push_cmd.do_read = 1'b1;
        end
        push_cmd.cell_row = {1'b0, in_ch.read_row};
        push_cmd.cell_col = {1'b0, in_ch.read_column};
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cur_col_nxt = cur_col_r;
      cur_row_nxt = cur_row_r;
    end
  end

  always_comb begin
    columns_nxt = columns_r;
    rows_nxt    = rows_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_COLUMNS: columns_nxt = cfg_ch.data;
        CFG_ROWS:    rows_nxt    = cfg_ch.data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
      cur_col_r <= 7'd0;
      cur_row_r <= 6'd0;
    end else begin
      columns_r <= columns_nxt;
      rows_r    <= rows_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

endmodule

/* rtl/tcw_queue.sv */
module tcw_queue import tcw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/tcw_back.sv */
module tcw_back import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      init_busy,
  tcw_out_if.source out_ch
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CLEAR_LAST = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROW_STEP   = CNT_W'(MAX_COLUMNS);

  back_state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] copy_len_r, copy_len_nxt;
  logic [CNT_W-1:0] blank_last_r, blank_last_nxt;
  logic [CNT_W-1:0] rd_src;
  cmd_t             cmd_r, cmd_nxt;
  logic             wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  logic [31:0]   grid_mem [DEPTH];
  logic [31:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] head_addr;

  logic out_free;
  logic pop_ok;
  logic res_load;
  logic rd_issue;

  assign init_busy = (state_r == BK_INIT);
  assign out_free  = ~out_valid_r | out_ch.ready;
  assign pop_ok    = (state_r == BK_IDLE) & ~q_empty & out_free;
  assign head_addr = AW'(int'(head.cell_row) * MAX_COLUMNS + int'(head.cell_col));
  assign rd_src    = cnt_r + ROW_STEP;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT: begin
        if (cnt_r == CLEAR_LAST) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (pop_ok) begin
          if (head.do_clear) begin
            state_nxt = BK_CLEAR;
          end else if (head.do_read) begin
            state_nxt = BK_READ;
          end else if (head.do_scroll) begin
            state_nxt = BK_COPY;
          end
        end
      end
      BK_READ:  state_nxt = BK_IDLE;
      BK_CLEAR: begin
        if (cnt_r == CLEAR_LAST) state_nxt = BK_IDLE;
      end
      BK_COPY: begin
        if (cnt_r == copy_len_r) state_nxt = BK_BLANK;
      end
      BK_BLANK: begin
        if (cnt_r == blank_last_r) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[AW-1:0];
    mem_wdata      = 32'd0;
    mem_raddr      = cnt_r[AW-1:0];
    cnt_nxt        = cnt_r;
    copy_len_nxt   = copy_len_r;
    blank_last_nxt = blank_last_r;
    cmd_nxt        = cmd_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    res_load       = 1'b0;
    res_nxt        = res_r;
    q_pop          = 1'b0;
    rd_issue       = 1'b0;
    case (state_r)
      BK_INIT: begin
        mem_we  = 1'b1;
        cnt_nxt = (cnt_r == CLEAR_LAST) ? '0 : cnt_r + CNT_W'(1);
      end
      BK_IDLE: begin
        if (pop_ok) begin
          q_pop          = 1'b1;
          cmd_nxt        = head;
          cnt_nxt        = '0;
          copy_len_nxt   = CNT_W'((int'(head.nrows) - 1) * MAX_COLUMNS);
          blank_last_nxt = CNT_W'(int'(head.nrows) * MAX_COLUMNS - 1);
          mem_raddr      = head_addr;
          if (head.put_cell) begin
            mem_we    = 1'b1;
            mem_waddr = head_addr;
            mem_wdata = head.cell_word;
          end
          if (!(head.do_clear || head.do_read || head.do_scroll)) begin
            res_load = 1'b1;
            res_nxt  = '{cursor_col: head.cursor_col, cursor_row: head.cursor_row,
                         scrolled: 1'b0, cell_data: 32'd0};
          end
        end
      end
      BK_READ: begin
        res_load = 1'b1;
        res_nxt  = '{cursor_col: cmd_r.cursor_col, cursor_row: cmd_r.cursor_row,
                     scrolled: 1'b0, cell_data: rd_data_r};
      end
      BK_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == CLEAR_LAST) begin
          res_load = 1'b1;
          res_nxt  = '{cursor_col: cmd_r.cursor_col, cursor_row: cmd_r.cursor_row,
                       scrolled: 1'b0, cell_data: 32'd0};
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      BK_COPY: begin
        // read cell k of the next row, write it back at k in the following cycle
        rd_issue    = (cnt_r < copy_len_r);
        mem_raddr   = rd_src[AW-1:0];
        wr_pend_nxt = rd_issue;
        wr_addr_nxt = cnt_r[AW-1:0];
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = rd_data_r;
        end
        if (rd_issue) cnt_nxt = cnt_r + CNT_W'(1);
      end
      BK_BLANK: begin
        mem_we = 1'b1;
        if (cnt_r == blank_last_r) begin
          res_load = 1'b1;
          res_nxt  = '{cursor_col: cmd_r.cursor_col, cursor_row: cmd_r.cursor_row,
                       scrolled: cmd_r.do_scroll, cell_data: 32'd0};
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = res_load | (out_valid_r & ~out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_len_r   <= copy_len_nxt;
    blank_last_r <= blank_last_nxt;
    cmd_r        <= cmd_nxt;
    wr_addr_r    <= wr_addr_nxt;
    if (res_load) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= grid_mem[mem_raddr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_column  = res_r.cursor_col;
  assign out_ch.cursor_row     = res_r.cursor_row;
  assign out_ch.scrolled       = res_r.scrolled;
  assign out_ch.cell_character = res_r.cell_data[31:24];
  assign out_ch.cell_red       = res_r.cell_data[23:16];
  assign out_ch.cell_green     = res_r.cell_data[15:8];
  assign out_ch.cell_blue      = res_r.cell_data[7:0];

endmodule

/* rtl/text_console_writer.sv */
// Channel  | Dir | Payload                                             | Handshake
// in_ch    | in  | operation character red green blue read_row/column  | valid/ready
// out_ch   | out | cursor_column cursor_row scrolled cell_*            | valid/ready
// cfg_ch   | in  | index data (0 columns, 1 rows)                      | valid/ready
//
// Front classifies each word combinationally and queues it (2 deep); the back end works
// it against one single-port-write grid RAM. A put of a character or control code is
// answered from idle unless it scrolls; a read waits for the registered RAM read;
// a clear sweeps the grid; a scroll copies rows up, one cell moved per cycle, and
// then blanks the last row. After reset the grid is swept to zero, in_ready low.
// A stalled output holds the back end; the queue lets the front keep taking words until it is full.
module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  cmd_t push_cmd;
  cmd_t head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic init_busy;

  tcw_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .push_cmd  (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  tcw_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/tcw_checker.sv */
module tcw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scrolled,
  input logic [6:0] out_cursor_column
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pend_r, pend_nxt;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // words accepted but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 4'd0)
    else $error("result without a pending word");

  a_init_block: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during grid clearing");

  a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cursor_column == 7'd0)
    else $error("scroll left cursor off column zero");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_scrolled      (out_ch.scrolled),
  .out_cursor_column (out_ch.cursor_column)
);
